// ===== rtl/kcs_pkg.sv =====
// ----------------------------------------------------------------------------
// kcs_pkg
// Shared types and constants for the keyframe curve sampler.
// ----------------------------------------------------------------------------
package kcs_pkg;

    localparam int NUM_TRACKS = 16;
    localparam int MAX_KEYS   = 64;
    localparam int FRAC_BITS  = 16;

    localparam int TRK_W  = $clog2(NUM_TRACKS);
    localparam int KEY_W  = $clog2(MAX_KEYS);
    localparam int CNT_W  = $clog2(MAX_KEYS + 1);
    localparam int ADDR_W = TRK_W + KEY_W;
    localparam int DEPTH  = NUM_TRACKS * MAX_KEYS;

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic               func;
        logic [3:0]         track;
        logic [31:0]        sample_time;
        logic signed [31:0] key_value;
        logic               looped;
    } kcs_in_t;

    typedef struct packed {
        logic signed [31:0] sampled_value;
        logic [1:0]         status;
    } kcs_out_t;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } kcs_div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quotient;
        logic [31:0] remainder;
    } kcs_div_rsp_t;

endpackage

// ===== rtl/kcs_div.sv =====
// ----------------------------------------------------------------------------
// kcs_div
// Restoring 64 / 32 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kcs_div
    import kcs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  kcs_div_req_t req,
    output kcs_div_rsp_t rsp
);

    logic [63:0] quo_reg;
    logic [31:0] rem_reg;
    logic [31:0] dvs_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] trial;

    assign trial = {rem_reg, quo_reg[63]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd64;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_reg <= 32'(trial - {1'b0, dvs_reg});
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[31:0];
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ===== rtl/keyframe_curve_sampler_unit.sv =====
// ----------------------------------------------------------------------------
// keyframe_curve_sampler_unit
// Keyframe tracks in block memory with sorted insert and linear sampling.
//
// Input channel in_valid/in_ready/in_data carries one transaction: an add
// (store key_value at sample_time on a track) or a query (sample a track).
// Output channel out_valid/out_ready/out_data returns one transaction per
// input: the sampled value and a status code.
// cfg_we/cfg_wdata writes tracks_in_use; write it only while idle.
// One item is handled at a time. A query scans the track linearly, reading
// one key at a time from the key memories, then runs a serial divide for
// interpolation; a looped wrap adds another serial divide. An add scans the
// same way, then shifts later keys up one at a time. An item with its track
// out of range finishes soonest and a looped query landing near the end of
// a full track takes longest; the scan, the shift and the divider set it.
// A finished result sits in the output register; the next item is taken
// once that register is loaded. A stalled receiver holds the block in its
// output state. Reset clears counts, duration and tracks_in_use; key
// memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module keyframe_curve_sampler_unit
    import kcs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  kcs_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output kcs_out_t out_data,
    input  logic     cfg_we,
    input  logic [4:0] cfg_wdata
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_MODW, S_RD, S_CMP, S_FOUND, S_SHRD, S_SHWR,
        S_DUR, S_MUL, S_DIVW, S_OUT
    } state_t;

    state_t       state_reg;
    kcs_in_t      item_reg;
    logic [31:0]  t_reg;
    logic [4:0]   tiu_reg;
    logic [31:0]  dur_reg;
    logic [CNT_W-1:0] cnt_reg [NUM_TRACKS];
    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] i_reg;
    logic [CNT_W-1:0] j_reg;
    logic [31:0]  prev_t_reg;
    logic [31:0]  prev_v_reg;
    logic [32:0]  mag_reg;
    logic         neg_reg;
    logic [31:0]  dt_reg;
    logic [31:0]  gap_reg;
    logic [31:0]  val_reg;
    logic [1:0]   stat_reg;
    logic         out_valid_reg;
    kcs_out_t     out_reg;

    logic [31:0]  times_mem [DEPTH];
    logic [31:0]  vals_mem  [DEPTH];
    logic [31:0]  rd_t_reg;
    logic [31:0]  rd_v_reg;
    logic         rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic         wr_t_en;
    logic         wr_v_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [31:0]  wr_t;
    logic [31:0]  wr_v;

    kcs_div_req_t div_req;
    kcs_div_rsp_t div_rsp;
    logic [TRK_W-1:0] trk;
    logic [32:0]  diff;
    logic [CNT_W-1:0] jm1;

    assign trk = item_reg.track[TRK_W-1:0];
    assign jm1 = j_reg - CNT_W'(1);
    assign diff = {rd_v_reg[31], rd_v_reg} - {prev_v_reg[31], prev_v_reg};

    kcs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = {trk, i_reg[KEY_W-1:0]};
        wr_t_en = 1'b0;
        wr_v_en = 1'b0;
        wr_addr = {trk, j_reg[KEY_W-1:0]};
        wr_t    = rd_t_reg;
        wr_v    = rd_v_reg;
        case (state_reg)
            S_RD:
            begin
                rd_en = (i_reg < n_reg);
            end
            S_FOUND:
            begin
                wr_addr = {trk, i_reg[KEY_W-1:0]};
                wr_v    = item_reg.key_value;
                wr_v_en = (item_reg.func == FUNC_ADD) && (i_reg < n_reg)
                          && (rd_t_reg == t_reg);
            end
            S_SHRD:
            begin
                if (j_reg > i_reg)
                begin
                    rd_en   = 1'b1;
                    rd_addr = {trk, jm1[KEY_W-1:0]};
                end
                else
                begin
                    wr_addr = {trk, i_reg[KEY_W-1:0]};
                    wr_t    = t_reg;
                    wr_v    = item_reg.key_value;
                    wr_t_en = 1'b1;
                    wr_v_en = 1'b1;
                end
            end
            S_SHWR:
            begin
                wr_t_en = 1'b1;
                wr_v_en = 1'b1;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_t_reg <= times_mem[rd_addr];
            rd_v_reg <= vals_mem[rd_addr];
        end
        if (wr_t_en)
            times_mem[wr_addr] <= wr_t;
        if (wr_v_en)
            vals_mem[wr_addr] <= wr_v;
    end

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = {32'd0, t_reg};
        div_req.divisor  = dur_reg;
        if (state_reg == S_CHECK)
        begin
            div_req.start = ({1'b0, item_reg.track} < tiu_reg)
                            && (item_reg.func == FUNC_QUERY)
                            && (t_reg > dur_reg) && item_reg.looped
                            && (dur_reg != 32'd0);
        end
        else if (state_reg == S_MUL)
        begin
            div_req.start    = (gap_reg != 32'd0);
            div_req.dividend = ({32'd0, mag_reg[31:0]} * {32'd0, dt_reg})
                               + (mag_reg[32] ? {dt_reg, 32'd0} : 64'd0);
            div_req.divisor  = gap_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tiu_reg       <= '0;
            dur_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_TRACKS; k++)
                cnt_reg[k] <= '0;
        end
        else
        begin
            if (cfg_we)
                tiu_reg <= cfg_wdata;
            if (out_valid_reg && out_ready && state_reg != S_OUT)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        item_reg  <= in_data;
                        t_reg     <= in_data.sample_time;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    n_reg    <= cnt_reg[trk];
                    i_reg    <= '0;
                    val_reg  <= '0;
                    stat_reg <= ({1'b0, item_reg.track} >= tiu_reg) ? ST_RANGE : ST_OK;
                    if ({1'b0, item_reg.track} >= tiu_reg)
                    begin
                        state_reg <= S_OUT;
                    end
                    else if (item_reg.func == FUNC_QUERY && t_reg > dur_reg)
                    begin
                        if (!item_reg.looped)
                        begin
                            t_reg     <= dur_reg;
                            state_reg <= S_RD;
                        end
                        else if (dur_reg == 32'd0)
                        begin
                            t_reg     <= '0;
                            state_reg <= S_RD;
                        end
                        else
                            state_reg <= S_MODW;
                    end
                    else
                        state_reg <= S_RD;
                end
                S_MODW:
                begin
                    if (div_rsp.done)
                    begin
                        t_reg     <= div_rsp.remainder;
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    state_reg <= (i_reg < n_reg) ? S_CMP : S_FOUND;
                end
                S_CMP:
                begin
                    if (rd_t_reg < t_reg)
                    begin
                        prev_t_reg <= rd_t_reg;
                        prev_v_reg <= rd_v_reg;
                        i_reg      <= i_reg + CNT_W'(1);
                        state_reg  <= S_RD;
                    end
                    else
                        state_reg <= S_FOUND;
                end
                S_FOUND:
                begin
                    if (item_reg.func == FUNC_ADD)
                    begin
                        if (i_reg < n_reg && rd_t_reg == t_reg)
                            state_reg <= S_DUR;
                        else if (n_reg >= CNT_W'(MAX_KEYS))
                        begin
                            stat_reg  <= ST_FULL;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            j_reg     <= n_reg;
                            state_reg <= S_SHRD;
                        end
                    end
                    else if (i_reg >= n_reg)
                    begin
                        val_reg   <= (n_reg != '0) ? prev_v_reg : 32'd0;
                        state_reg <= S_OUT;
                    end
                    else if (i_reg == '0)
                    begin
                        val_reg   <= rd_v_reg;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        neg_reg   <= diff[32];
                        mag_reg   <= diff[32] ? 33'(-diff) : diff;
                        dt_reg    <= t_reg - prev_t_reg;
                        gap_reg   <= rd_t_reg - prev_t_reg;
                        state_reg <= S_MUL;
                    end
                end
                S_SHRD:
                begin
                    if (j_reg > i_reg)
                        state_reg <= S_SHWR;
                    else
                    begin
                        cnt_reg[trk] <= n_reg + CNT_W'(1);
                        state_reg    <= S_DUR;
                    end
                end
                S_SHWR:
                begin
                    j_reg     <= jm1;
                    state_reg <= S_SHRD;
                end
                S_DUR:
                begin
                    if (t_reg > dur_reg)
                        dur_reg <= t_reg;
                    state_reg <= S_OUT;
                end
                S_MUL:
                begin
                    if (gap_reg == 32'd0)
                    begin
                        val_reg   <= rd_v_reg;
                        state_reg <= S_OUT;
                    end
                    else
                        state_reg <= S_DIVW;
                end
                S_DIVW:
                begin
                    if (div_rsp.done)
                    begin
                        val_reg   <= neg_reg ? prev_v_reg - div_rsp.quotient[31:0]
                                             : prev_v_reg + div_rsp.quotient[31:0];
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg         <= 1'b1;
                        out_reg.sampled_value <= val_reg;
                        out_reg.status        <= stat_reg;
                        state_reg             <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    property p_count_bound;
        @(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (cnt_reg[trk] <= CNT_W'(MAX_KEYS));
    endproperty
    a_count_bound: assert property (p_count_bound)
        else $error("track key count above capacity");

    property p_div_idle_start;
        @(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy;
    endproperty
    a_div_idle_start: assert property (p_div_idle_start)
        else $error("divider started while busy");

    property p_status_code;
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.status == ST_OK || out_reg.status == ST_RANGE
                           || out_reg.status == ST_FULL);
    endproperty
    a_status_code: assert property (p_status_code)
        else $error("bad status code");

    property p_err_zero;
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status != ST_OK) |-> (out_reg.sampled_value == 32'd0);
    endproperty
    a_err_zero: assert property (p_err_zero)
        else $error("error result carries nonzero value");

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// keyframe_curve_sampler_unit testbench
// Drives add and query transactions against the curve sampler, predicts each
// result with a behavioral copy of the track tables, and checks every output
// transaction in order. Covers range errors, full tracks, wrap and clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import kcs_pkg::*;

    class curve_scoreboard;
        logic [31:0] times [NUM_TRACKS][MAX_KEYS];
        logic [31:0] values [NUM_TRACKS][MAX_KEYS];
        int          counts [NUM_TRACKS];
        logic [31:0] duration;
        logic [4:0]  tracks_cfg;
        kcs_out_t    pending [$];
        int          mismatches;

        function void clear();
            foreach (counts[i])
                counts[i] = 0;
            duration = 0;
            tracks_cfg = 0;
            mismatches = 0;
            pending.delete();
        endfunction

        function void queue_result(kcs_out_t r);
            pending = {pending, r};
        endfunction

        function int find_slot(int trk, logic [31:0] t);
            int i;
            i = 0;
            while (i < counts[trk] && times[trk][i] < t)
                i++;
            return i;
        endfunction

        function void note_input(kcs_in_t it);
            kcs_out_t r;
            int trk, n, pos, i;
            logic [31:0] t, tp, tn, gap;
            longint vp, vn, diff, res;
            longint unsigned mag, q;
            r = '0;
            trk = it.track;
            t = it.sample_time;
            if (trk >= tracks_cfg || trk >= NUM_TRACKS)
            begin
                r.status = ST_RANGE;
                queue_result(r);
                return;
            end
            n = counts[trk];
            if (it.func == FUNC_ADD)
            begin
                pos = find_slot(trk, t);
                if (pos < n && times[trk][pos] == t)
                begin
                    values[trk][pos] = it.key_value;
                end
                else if (n >= MAX_KEYS)
                begin
                    r.status = ST_FULL;
                    queue_result(r);
                    return;
                end
                else
                begin
                    for (i = n; i > pos; i--)
                    begin
                        times[trk][i] = times[trk][i-1];
                        values[trk][i] = values[trk][i-1];
                    end
                    times[trk][pos] = t;
                    values[trk][pos] = it.key_value;
                    counts[trk] = n + 1;
                end
                if (t > duration)
                    duration = t;
                queue_result(r);
                return;
            end
            if (t > duration)
            begin
                if (it.looped)
                    t = (duration != 0) ? t % duration : 0;
                else
                    t = duration;
            end
            pos = find_slot(trk, t);
            if (pos >= n)
            begin
                res = n ? longint'(signed'(values[trk][n-1])) : 0;
            end
            else if (pos == 0)
            begin
                res = longint'(signed'(values[trk][0]));
            end
            else
            begin
                tp = times[trk][pos-1];
                tn = times[trk][pos];
                vp = longint'(signed'(values[trk][pos-1]));
                vn = longint'(signed'(values[trk][pos]));
                gap = tn - tp;
                diff = vn - vp;
                mag = (diff < 0) ? longint'(-diff) : diff;
                q = (mag * longint'({32'd0, t - tp})) / longint'({32'd0, gap});
                res = (diff < 0) ? vp - longint'(q) : vp + longint'(q);
            end
            r.sampled_value = res[31:0];
            queue_result(r);
        endfunction

        function void check_result(kcs_out_t got);
            kcs_out_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: value %h status %0d",
                             got.sampled_value, got.status);
                return;
            end
            want = pending.pop_front();
            if (got.sampled_value !== want.sampled_value || got.status !== want.status)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected value %h status %0d, got value %h status %0d",
                             want.sampled_value, want.status,
                             got.sampled_value, got.status);
            end
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    kcs_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    kcs_out_t out_data;
    logic     cfg_we;
    logic [4:0] cfg_wdata;

    curve_scoreboard sb;
    bit   idle_enable;
    bit   hold_request;
    int   quiet_cycles;
    logic [31:0] time_pool [8];

    keyframe_curve_sampler_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_input(in_data);
            if (out_valid && out_ready)
                sb.check_result(out_data);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000)
        begin
            $display("keyframe_curve_sampler_unit regression: fail");
            $finish;
        end
    end

    // receiver: random stall bursts, or one long hold on request
    initial
    begin : receiver
        int n;
        bit held;
        held = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request && !held)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (600) @(negedge clk);
                out_ready <= 1'b1;
            end
            else if (idle_enable && $urandom_range(0, 7) == 0)
            begin
                n = $urandom_range(1, 6);
                out_ready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic send(input kcs_in_t it);
        int n;
        if (idle_enable && $urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    task automatic write_tracks(input logic [4:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.tracks_cfg = v;
    endtask

    function automatic kcs_in_t make_item(logic f, logic [3:0] trk, logic [31:0] t,
                                          logic [31:0] v, logic lp);
        kcs_in_t it;
        it.func = f;
        it.track = trk;
        it.sample_time = t;
        it.key_value = v;
        it.looped = lp;
        return it;
    endfunction

    function automatic kcs_in_t rand_item(int trk_hi);
        logic [31:0] t, v;
        case ($urandom_range(0, 3))
            0: t = $urandom();
            1: t = $urandom_range(0, 200);
            default: t = time_pool[$urandom_range(0, 7)] + $urandom_range(0, 3);
        endcase
        v = $urandom();
        return make_item(1'($urandom_range(0, 1)), 4'($urandom_range(0, trk_hi)), t, v,
                         1'($urandom_range(0, 1)));
    endfunction

    initial
    begin : stimulus
        int i;
        sb = new();
        sb.clear();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        idle_enable = 1'b0;
        hold_request = 1'b0;
        foreach (time_pool[k])
            time_pool[k] = $urandom_range(0, 5000);
        time_pool[7] = 32'hffff_fff0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: nothing in use yet
        send(make_item(FUNC_ADD, 4'd0, 32'd10, 32'd5, 1'b0));
        drain();
        write_tracks(5'd16);
        send(make_item(FUNC_QUERY, 4'd3, 32'd0, 32'd0, 1'b0));
        send(make_item(FUNC_ADD, 4'd3, 32'd100, 32'h7fff_ffff, 1'b0));
        send(make_item(FUNC_ADD, 4'd3, 32'd300, 32'h8000_0000, 1'b0));
        send(make_item(FUNC_ADD, 4'd3, 32'd200, 32'h0001_0000, 1'b1));
        send(make_item(FUNC_QUERY, 4'd3, 32'd0, 32'd0, 1'b0));
        send(make_item(FUNC_QUERY, 4'd3, 32'd150, 32'hffff_ffff, 1'b0));
        send(make_item(FUNC_QUERY, 4'd3, 32'd250, 32'd0, 1'b1));
        send(make_item(FUNC_QUERY, 4'd3, 32'd200, 32'd0, 1'b0));
        send(make_item(FUNC_QUERY, 4'd3, 32'hffff_ffff, 32'd0, 1'b0));
        send(make_item(FUNC_QUERY, 4'd3, 32'hffff_ffff, 32'd0, 1'b1));
        send(make_item(FUNC_ADD, 4'd3, 32'd200, 32'hfff0_0000, 1'b0));
        send(make_item(FUNC_QUERY, 4'd3, 32'd120, 32'd0, 1'b0));
        send(make_item(FUNC_ADD, 4'd15, 32'hffff_ffff, 32'd1, 1'b0));
        send(make_item(FUNC_QUERY, 4'd15, 32'd7, 32'd0, 1'b1));
        // fill track 5 to capacity, then overflow and overwrite
        for (i = 0; i < MAX_KEYS; i++)
            send(make_item(FUNC_ADD, 4'd5, 32'(i * 3), $urandom(), 1'b0));
        send(make_item(FUNC_ADD, 4'd5, 32'd1, 32'd9, 1'b0));
        send(make_item(FUNC_ADD, 4'd5, 32'd3, 32'd9, 1'b0));
        send(make_item(FUNC_QUERY, 4'd5, 32'd100, 32'd0, 1'b0));
        drain();

        // out-of-range query and looped query on fresh config change
        write_tracks(5'd4);
        send(make_item(FUNC_QUERY, 4'd4, 32'd0, 32'd0, 1'b0));
        send(make_item(FUNC_QUERY, 4'd2, 32'd77, 32'd0, 1'b1));
        drain();

        idle_enable = 1'b1;
        for (i = 0; i < 150; i++)
            send(rand_item(5));
        drain();
        write_tracks(5'd31);
        for (i = 0; i < 150; i++)
        begin
            if (i == 20)
                hold_request = 1'b1;
            send(rand_item(15));
        end
        drain();
        write_tracks(5'd1);
        for (i = 0; i < 60; i++)
            send(rand_item(3));
        drain();
        write_tracks(5'd16);
        for (i = 0; i < 60; i++)
            send(rand_item(15));
        idle_enable = 1'b0;
        for (i = 0; i < 60; i++)
            send(rand_item(15));
        drain();

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("keyframe_curve_sampler_unit regression: pass");
        else
            $display("keyframe_curve_sampler_unit regression: fail");
        $finish;
    end
endmodule

// ===== keyframe_curve_sampler_unit.f =====
rtl/kcs_pkg.sv
rtl/kcs_div.sv
rtl/keyframe_curve_sampler_unit.sv
tb/testbench.sv
